FILE: src/bpc_pkg.sv
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int THR_W   = 8;
    localparam int CFG_IDX_W = 2;

    // command codes
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // press event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_SINGLE = 2'd1;
    localparam logic [1:0] EV_DOUBLE = 2'd2;
    localparam logic [1:0] EV_POWER  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_WAIT = 2'd2;

    typedef struct packed {
        logic [THR_W-1:0] long_press_ticks;
        logic [THR_W-1:0] min_press_ticks;
        logic [THR_W-1:0] second_wait_ticks;
    } cfg_t;

    typedef struct packed {
        logic command;
        logic button_down;
        logic powered_down;
    } item_t;

    typedef struct packed {
        logic [1:0] press_event;
        logic       busy_res;
    } result_t;

endpackage

FILE: src/button_press_classifier_core.sv
`timescale 1ns / 1ps

// Push-button press classifier.
// Input stream: one request per press edge (tuser = 0) or check tick
// (tuser = 1). Tick requests carry the sampled pin level, edge requests the
// sleep flag. Every request yields exactly one result on the output stream:
// the press event (none, single, double, long power press) and whether a
// press sequence is still running afterwards.
// Thresholds are set through the write port (index 0 long press, 1 minimum
// press, 2 second-press wait); write only while the block is idle.
// A request is held in the input register; its result is then loaded into
// the result register, which drives m_tdata.
// Throughput: one request per cycle while the receiver takes results; the
// phase and tick counter update when a request moves between the two registers.
// Reset: thresholds return to 20/1/5, phase to idle, counter to zero, both
// register stages empty.
// When the receiver stalls the result register holds; the input register
// still takes one more request, after which s_tready drops until the
// result is taken.

module button_press_classifier_core #(
    parameter int COUNT_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [0] button_down, [1] powered_down
    input  logic                            s_tuser,  // [0] command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,  // [1:0] press_event, [2] busy_res
    input  logic                            cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpc_pkg::THR_W-1:0]       cfg_wdata
);
    import bpc_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    advance;

    bpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.command      <= s_tuser;
            in_item_reg.button_down  <= s_tdata[0];
            in_item_reg.powered_down <= s_tdata[1];
        end
    end

    bpc_fsm #(
        .COUNT_BITS (COUNT_BITS)
    ) u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_res_reg.busy_res, out_res_reg.press_event};

    a_event_ends_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != EV_NONE |-> !m_tdata[2])
        else $error("press event reported while sequence still busy");

    a_edge_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.command == CMD_EDGE |-> res.press_event == EV_NONE)
        else $error("press edge produced an event");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("result register not loaded after advance");

    a_empty_output_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

FILE: src/bpc_cfg.sv
`timescale 1ns / 1ps

module bpc_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpc_pkg::THR_W-1:0]       cfg_wdata,
    output bpc_pkg::cfg_t                   cfg
);
    import bpc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks  <= THR_W'(20);
            cfg_reg.min_press_ticks   <= THR_W'(1);
            cfg_reg.second_wait_ticks <= THR_W'(5);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LONG_PRESS:  cfg_reg.long_press_ticks  <= cfg_wdata;
                REG_MIN_PRESS:   cfg_reg.min_press_ticks   <= cfg_wdata;
                REG_SECOND_WAIT: cfg_reg.second_wait_ticks <= cfg_wdata;
                default:         ; // unused index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/bpc_fsm.sv
`timescale 1ns / 1ps

module bpc_fsm #(
    parameter int COUNT_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  bpc_pkg::item_t    item,
    input  bpc_pkg::cfg_t     cfg,
    output bpc_pkg::result_t  res
);
    import bpc_pkg::*;

    localparam int CW = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_WAIT2  = 2'd2;
    localparam logic [1:0] PH_SECOND = 2'd3;

    logic [1:0]            phase_reg, phase_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] count_inc;
    logic [CW-1:0]         count_w, long_w, min_w, wait_w;
    logic [1:0]            ev;

    assign count_w = CW'(count_reg);
    assign long_w  = CW'(cfg.long_press_ticks);
    assign min_w   = CW'(cfg.min_press_ticks);
    assign wait_w  = CW'(cfg.second_wait_ticks);

    // saturating increment
    assign count_inc = (&count_reg) ? count_reg : count_reg + COUNT_BITS'(1);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        ev         = EV_NONE;
        if (item.command == CMD_EDGE)
        begin
            if (phase_reg == PH_IDLE && !item.powered_down)
                phase_next = PH_FIRST;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE: ;
                PH_FIRST:
                begin
                    if (item.button_down)
                    begin
                        if (count_w >= long_w)
                        begin
                            ev         = EV_POWER;
                            phase_next = PH_IDLE;
                            count_next = '0;
                        end
                        else
                            count_next = count_inc;
                    end
                    else if (count_w < min_w)
                    begin
                        phase_next = PH_IDLE;   // bounce
                        count_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_WAIT2;
                        count_next = '0;
                    end
                end
                PH_WAIT2:
                begin
                    if (item.button_down)
                    begin
                        phase_next = PH_SECOND;
                        count_next = '0;
                    end
                    else if (count_w < wait_w)
                        count_next = count_inc;
                    else
                    begin
                        ev         = EV_SINGLE;
                        phase_next = PH_IDLE;
                        count_next = '0;
                    end
                end
                PH_SECOND:
                begin
                    if (item.button_down)
                    begin
                        if (count_w < long_w)
                            count_next = count_inc;
                        else
                        begin
                            ev         = EV_POWER;
                            phase_next = PH_IDLE;
                            count_next = '0;
                        end
                    end
                    else
                    begin
                        ev         = (count_w < min_w) ? EV_SINGLE : EV_DOUBLE;
                        phase_next = PH_IDLE;
                        count_next = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    assign res.press_event = ev;
    assign res.busy_res    = (phase_next != PH_IDLE);

endmodule

FILE: tb/button_press_classifier_core_tb.sv
`timescale 1ns / 1ps

module button_press_classifier_core_tb;

    import bpc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_WAIT2  = 2'd2,
        PH_SECOND = 2'd3
    } press_phase_e;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [THR_W-1:0] cfg_wdata = '0;

    button_press_classifier_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // thresholds as last written, and the classifier state
    logic [7:0] long_thr = 8'd20;
    logic [7:0] min_thr = 8'd1;
    logic [7:0] wait_thr = 8'd5;
    press_phase_e press_phase = PH_IDLE;
    logic [7:0] hold_count = 8'd0;

    item_t pending_reqs[$];
    result_t expected_results[$];
    item_t cur_req;
    int error_count = 0;
    int queued_count = 0;
    int burst_left = 1;
    int gap_left = 0;
    int rx_mode = 0;
    int rx_left = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("button_press_classifier_core_tb: errors");
        $finish;
    end

    function automatic result_t classify_press(item_t req);
        result_t res;
        logic [1:0] ev;
        ev = EV_NONE;
        if (req.command == CMD_EDGE)
        begin
            if (press_phase == PH_IDLE && !req.powered_down)
                press_phase = PH_FIRST;
        end
        else
        begin
            case (press_phase)
                PH_FIRST:
                begin
                    if (req.button_down)
                    begin
                        if (hold_count >= long_thr)
                            ev = EV_POWER;
                        else if (hold_count != COUNT_MAX)
                            hold_count = hold_count + 8'd1;
                    end
                    else if (hold_count < min_thr)
                        ev = EV_NONE;
                    else
                    begin
                        hold_count = 8'd0;
                        press_phase = PH_WAIT2;
                    end
                    // power press and bounce both end the sequence
                    if (ev == EV_POWER || (!req.button_down && press_phase == PH_FIRST))
                    begin
                        press_phase = PH_IDLE;
                        hold_count = 8'd0;
                    end
                end
                PH_WAIT2:
                begin
                    if (req.button_down)
                    begin
                        hold_count = 8'd0;
                        press_phase = PH_SECOND;
                    end
                    else if (hold_count < wait_thr)
                    begin
                        if (hold_count != COUNT_MAX)
                            hold_count = hold_count + 8'd1;
                    end
                    else
                    begin
                        ev = EV_SINGLE;
                        press_phase = PH_IDLE;
                        hold_count = 8'd0;
                    end
                end
                PH_SECOND:
                begin
                    if (req.button_down && hold_count < long_thr)
                    begin
                        if (hold_count != COUNT_MAX)
                            hold_count = hold_count + 8'd1;
                    end
                    else
                    begin
                        if (req.button_down)
                            ev = EV_POWER;
                        else if (hold_count < min_thr)
                            ev = EV_SINGLE;
                        else
                            ev = EV_DOUBLE;
                        press_phase = PH_IDLE;
                        hold_count = 8'd0;
                    end
                end
                default:
                    ev = EV_NONE;
            endcase
        end
        res.press_event = ev;
        res.busy_res = (press_phase != PH_IDLE);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
        error_count++;
    endtask

    // request driver: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'd0;
            s_tuser <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(classify_press(cur_req));
            if (s_tvalid && !s_tready)
                ;
            else if (gap_left != 0)
            begin
                s_tvalid <= 1'b0;
                gap_left--;
            end
            else if (pending_reqs.size() != 0)
            begin
                cur_req = pending_reqs.pop_front();
                s_tdata <= {6'd0, cur_req.powered_down, cur_req.button_down};
                s_tuser <= cur_req.command;
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        burst_left = $urandom_range(40, 100);
                        gap_left = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = $urandom_range(0, 5);
                    end
                end
                else
                    burst_left--;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result monitor with its own stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", int'(m_tdata), -1);
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[1:0] !== want.press_event)
                        report_mismatch("press_event", int'(m_tdata[1:0]),
                                        int'(want.press_event));
                    if (m_tdata[2] !== want.busy_res)
                        report_mismatch("busy_res", int'(m_tdata[2]), int'(want.busy_res));
                end
            end
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 80);
            end
            else
                rx_left--;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (rx_left % 4 == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic push_item(input logic cmd, input logic down, input logic sleep);
        item_t req;
        req.command = cmd;
        req.button_down = down;
        req.powered_down = sleep;
        pending_reqs.push_back(req);
        queued_count++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_LONG_PRESS: long_thr = val;
            REG_MIN_PRESS: min_thr = val;
            REG_SECOND_WAIT: wait_thr = val;
            default: ;
        endcase
    endtask

    task automatic set_thresholds(input logic [7:0] lp, input logic [7:0] mp,
                                  input logic [7:0] sw);
        wait_idle();
        write_reg(REG_LONG_PRESS, lp);
        write_reg(REG_MIN_PRESS, mp);
        write_reg(REG_SECOND_WAIT, sw);
        if ($urandom_range(0, 1) == 0)
            write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // lengths cluster around a threshold when it is within reach
    function automatic int pick_len(input logic [7:0] thr, input int cap);
        int n;
        if (int'(thr) <= cap && $urandom_range(0, 1) == 0)
        begin
            n = int'(thr) - 1 + $urandom_range(0, 2);
            if (n < 0)
                n = 0;
        end
        else
            n = $urandom_range(0, cap);
        return n;
    endfunction

    task automatic add_ticks(input logic down, input int n);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 11) == 0)
                push_item(CMD_EDGE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            push_item(CMD_TICK, down, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic add_press_seq(input int cap);
        push_item(CMD_EDGE, 1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0));
        add_ticks(1'b1, pick_len(($urandom_range(0, 1) != 0) ? long_thr : min_thr, cap));
        add_ticks(1'b0, 1);
        add_ticks(1'b0, pick_len(wait_thr, cap));
        if ($urandom_range(0, 2) != 0)
        begin
            add_ticks(1'b1, 1 + pick_len(($urandom_range(0, 1) != 0) ? long_thr : min_thr,
                                         cap));
            add_ticks(1'b0, 1);
        end
        add_ticks(1'b0, $urandom_range(0, 2));
    endtask

    task automatic run_random(input int n, input int cap);
        int stop_at;
        stop_at = queued_count + n;
        while (queued_count < stop_at)
        begin
            if ($urandom_range(0, 9) < 7)
                add_press_seq(cap);
            else
                repeat ($urandom_range(1, 6))
                    push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_random_cfg(input int n);
        logic [7:0] lp;
        logic [7:0] mp;
        logic [7:0] sw;
        int cap;
        lp = 8'($urandom_range(0, 8));
        mp = 8'($urandom_range(0, 8));
        sw = 8'($urandom_range(0, 8));
        set_thresholds(lp, mp, sw);
        cap = int'(lp);
        if (int'(mp) > cap)
            cap = int'(mp);
        if (int'(sw) > cap)
            cap = int'(sw);
        run_random(n, cap + 3);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset thresholds 20/1/5
        push_item(CMD_TICK, 1'b1, 1'b0);   // tick in idle
        push_item(CMD_TICK, 1'b0, 1'b1);
        push_item(CMD_EDGE, 1'b0, 1'b1);   // edge while asleep
        push_item(CMD_EDGE, 1'b1, 1'b0);
        push_item(CMD_EDGE, 1'b0, 1'b1);   // edge while busy
        push_item(CMD_TICK, 1'b1, 1'b0);
        push_item(CMD_TICK, 1'b0, 1'b0);
        repeat (6) push_item(CMD_TICK, 1'b0, 1'b1);   // wait runs out: single
        push_item(CMD_EDGE, 1'b0, 1'b0);
        push_item(CMD_TICK, 1'b0, 1'b0);   // bounce
        push_item(CMD_EDGE, 1'b0, 1'b0);
        push_item(CMD_TICK, 1'b1, 1'b0);
        push_item(CMD_TICK, 1'b0, 1'b0);
        push_item(CMD_TICK, 1'b1, 1'b1);
        push_item(CMD_TICK, 1'b1, 1'b0);
        push_item(CMD_TICK, 1'b0, 1'b0);   // double
        push_item(CMD_EDGE, 1'b0, 1'b0);
        push_item(CMD_TICK, 1'b1, 1'b0);
        push_item(CMD_TICK, 1'b0, 1'b0);
        push_item(CMD_TICK, 1'b1, 1'b0);
        push_item(CMD_TICK, 1'b0, 1'b1);   // short second press: single
        run_random(80, 24);

        set_thresholds(8'd3, 8'd2, 8'd4);
        run_random(100, 8);

        set_thresholds(8'd0, 8'd0, 8'd0);
        run_random(60, 3);

        // long press at the top threshold
        set_thresholds(8'd255, 8'd0, 8'd0);
        push_item(CMD_EDGE, 1'b0, 1'b0);
        repeat (256) push_item(CMD_TICK, 1'b1, 1'($urandom_range(0, 1)));
        run_random(40, 6);

        // longest wait for a second press
        set_thresholds(8'd255, 8'd0, 8'd255);
        push_item(CMD_EDGE, 1'b1, 1'b0);
        push_item(CMD_TICK, 1'b0, 1'b0);
        repeat (256) push_item(CMD_TICK, 1'b0, 1'($urandom_range(0, 1)));
        run_random(40, 6);

        set_thresholds(8'd0, 8'd255, 8'd255);
        run_random(60, 6);

        run_random_cfg(80);
        run_random_cfg(80);

        wait_idle();
        if (error_count == 0)
            $display("button_press_classifier_core_tb: clean");
        else
            $display("button_press_classifier_core_tb: errors");
        $finish;
    end

endmodule

FILE: files.f
src/bpc_pkg.sv
src/bpc_cfg.sv
src/bpc_fsm.sv
src/button_press_classifier_core.sv
tb/button_press_classifier_core_tb.sv
